@@ src/fbfla_pkg.sv @@
package fbfla_pkg;

  // Pool geometry.
  localparam int unsigned MAX_BLOCKS    = 1024;
  localparam int unsigned IDX_W         = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned POINTER_BYTES = 8;
  localparam int unsigned HEADER_BYTES  = POINTER_BYTES;
  localparam int unsigned FREE_SAT      = (1 << CNT_W) - 1;

  // Field and register widths.
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned POOL_W = 23;
  localparam int unsigned BLK_W  = 13;
  localparam int unsigned ALN_W  = BLK_W + 1;
  localparam int unsigned OFS_W  = 22;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register reset values and the pool geometry they give.
  localparam int unsigned RST_POOL    = 8200;
  localparam int unsigned RST_BLOCK   = 8;
  localparam int unsigned RST_ALIGNED =
    (RST_BLOCK + POINTER_BYTES - 1) / POINTER_BYTES * POINTER_BYTES;
  localparam int unsigned RST_QUOT    =
    (RST_ALIGNED == 0 || RST_POOL <= HEADER_BYTES) ? 0 :
    (RST_POOL - HEADER_BYTES) / RST_ALIGNED;
  localparam int unsigned RST_COUNT   = (RST_QUOT > MAX_BLOCKS) ? MAX_BLOCKS : RST_QUOT;

  // Register indexes, taken from the word address.
  localparam logic REG_POOL  = 1'b0;
  localparam logic REG_BLOCK = 1'b1;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_INIT  = 2'd2
  } func_e;

  // Divider request and status.
  typedef struct packed {
    logic              start;
    logic [POOL_W-1:0] dividend;
    logic [ALN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [POOL_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/fbfla_req_if.sv @@
interface fbfla_req_if import fbfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  free_index;

  modport source (output valid, func, free_index, input ready);
  modport sink   (input valid, func, free_index, output ready);
endinterface

@@ src/fbfla_rsp_if.sv @@
interface fbfla_rsp_if import fbfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [IDX_W-1:0] given_index;
  logic [OFS_W-1:0] given_offset;
  logic [CNT_W-1:0] free_count;

  modport source (output valid, ok, given_index, given_offset, free_count, input ready);
  modport sink   (input valid, ok, given_index, given_offset, free_count, output ready);
endinterface

@@ src/fbfla_div.sv @@
module fbfla_div import fbfla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t div_req_i,
  output div_rsp_t div_rsp_o
);

  localparam int unsigned STEP_W = $clog2(POOL_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ALN_W-1:0]  rem_q, rem_d;
  logic [POOL_W-1:0] quo_q, quo_d;
  logic [ALN_W-1:0]  dsr_q;
  logic [ALN_W:0]    trial;
  logic [ALN_W:0]    diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[POOL_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? diff[ALN_W-1:0] : trial[ALN_W-1:0];
    quo_d = {quo_q[POOL_W-2:0], fits};
  end

  // Step counter and busy flag.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (div_req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(POOL_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Partial remainder, quotient and divisor.
  always_ff @(posedge clk_i) begin
    if (div_req_i.start) begin
      rem_q <= '0;
      quo_q <= div_req_i.dividend;
      dsr_q <= div_req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign div_rsp_o.busy     = busy_q;
  assign div_rsp_o.quotient = quo_q;

endmodule

@@ src/fixed_block_free_list_allocator.sv @@
// Free-list allocator for equal-size blocks with a link memory and a result skid register.
// Free, allocate from the untouched region and failed requests: result via the skid and
// output registers, one request per cycle while responses are taken. Allocate from the
// freed stack: no request is taken in the pop state. Initialize: uses the bit-serial
// divider (23 steps). Reset is asynchronous and active low; it leaves the pool
// initialized from the register reset values, with no clearing pass of the link memory.
module fixed_block_free_list_allocator import fbfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  fbfla_req_if.sink         req_i,
  fbfla_rsp_if.source       rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DIV
  } state_e;

  localparam int unsigned PROD_W = IDX_W + ALN_W;

  // Configuration registers.
  logic [POOL_W-1:0] pool_q;
  logic [BLK_W-1:0]  block_q;
  logic              cfg_we;

  // Allocator state.
  state_e            state_q, state_d;
  logic [ALN_W-1:0]  aligned_q, aligned_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  mark_q, mark_d;
  logic [IDX_W-1:0]  top_q, top_d;
  logic              nonempty_q, nonempty_d;
  logic [IDX_W-1:0]  pop_idx_q, pop_idx_d;
  logic              zero_q, zero_d;

  // Link memory: valid bit and next index of each stacked block.
  logic [IDX_W:0]    link_mem [MAX_BLOCKS];
  logic [IDX_W:0]    link_rd_q;
  logic              mem_we;

  // Result stages.
  logic              pend_valid_q, pend_valid_d;
  logic              pend_ok_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic [OFS_W-1:0]  pend_ofs_q;
  logic [CNT_W-1:0]  pend_free_q;
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [OFS_W-1:0]  out_ofs_q;
  logic [CNT_W-1:0]  out_free_q;

  // Core control and result values.
  logic              accept;
  logic              can_load;
  logic              pend_move;
  logic              pend_load;
  logic              res_ok;
  logic              res_alloc;
  logic [IDX_W-1:0]  res_idx;
  logic [OFS_W-1:0]  res_ofs;
  logic [PROD_W-1:0] res_prod;
  logic [ALN_W:0]    align_sum;
  logic [ALN_W-1:0]  align_new;
  logic [CNT_W-1:0]  count;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  fbfla_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[ADDR_W-1] == REG_BLOCK) ? DATA_W'(block_q) : DATA_W'(pool_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= POOL_W'(RST_POOL);
      block_q <= BLK_W'(RST_BLOCK);
    end else if (cfg_we) begin
      if (paddr[ADDR_W-1] == REG_POOL) begin
        pool_q <= pwdata[POOL_W-1:0];
      end else begin
        block_q <= pwdata[BLK_W-1:0];
      end
    end
  end

  // Handshake and skid control.
  assign pend_move   = pend_valid_q && (!out_valid_q || rsp_o.ready);
  assign can_load    = !pend_valid_q || pend_move;
  assign req_i.ready = (state_q == S_IDLE) && can_load;
  assign accept      = req_i.valid && req_i.ready;

  // Block size rounded up to the pointer size.
  assign align_sum = {2'b00, block_q} + (ALN_W + 1)'(POINTER_BYTES - 1);
  assign align_new = ALN_W'((align_sum / POINTER_BYTES) * POINTER_BYTES);

  // Block count from the divider, saturated.
  assign count = (zero_q || div_rsp.quotient == '0) ? '0 :
                 (div_rsp.quotient > POOL_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) :
                 div_rsp.quotient[CNT_W-1:0];

  // Request decode and state update.
  always_comb begin
    state_d      = state_q;
    aligned_d    = aligned_q;
    total_d      = total_q;
    free_d       = free_q;
    mark_d       = mark_q;
    top_d        = top_q;
    nonempty_d   = nonempty_q;
    pop_idx_d    = pop_idx_q;
    zero_d       = zero_q;
    mem_we       = 1'b0;
    pend_load    = 1'b0;
    res_ok       = 1'b0;
    res_alloc    = 1'b0;
    res_idx      = '0;
    div_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.func)
            FUNC_ALLOC: begin
              if (nonempty_q) begin
                pop_idx_d = top_q;
                state_d   = S_POP;
              end else if (mark_q < total_q) begin
                res_ok    = 1'b1;
                res_alloc = 1'b1;
                res_idx   = mark_q[IDX_W-1:0];
                mark_d    = mark_q + 1'b1;
                free_d    = (free_q != '0) ? free_q - 1'b1 : free_q;
                pend_load = 1'b1;
              end else begin
                pend_load = 1'b1;
              end
            end
            FUNC_FREE: begin
              if ({1'b0, req_i.free_index} < total_q) begin
                mem_we     = 1'b1;
                top_d      = req_i.free_index;
                nonempty_d = 1'b1;
                free_d     = (free_q != CNT_W'(FREE_SAT)) ? free_q + 1'b1 : free_q;
                res_ok     = 1'b1;
              end
              pend_load = 1'b1;
            end
            FUNC_INIT: begin
              aligned_d        = align_new;
              zero_d           = (align_new == '0) || (pool_q <= POOL_W'(HEADER_BYTES));
              div_req.start    = 1'b1;
              div_req.dividend = (pool_q > POOL_W'(HEADER_BYTES)) ?
                                 pool_q - POOL_W'(HEADER_BYTES) : '0;
              div_req.divisor  = align_new;
              state_d          = S_DIV;
            end
            default: begin
              pend_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (can_load) begin
          if (link_rd_q[IDX_W]) begin
            top_d = link_rd_q[IDX_W-1:0];
          end else begin
            nonempty_d = 1'b0;
          end
          res_ok    = 1'b1;
          res_alloc = 1'b1;
          res_idx   = pop_idx_q;
          free_d    = (free_q != '0) ? free_q - 1'b1 : free_q;
          pend_load = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_rsp.busy && can_load) begin
          total_d    = count;
          free_d     = count;
          mark_d     = '0;
          top_d      = '0;
          nonempty_d = 1'b0;
          res_ok     = (count != '0);
          pend_load  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Byte offset of an allocated block.
  assign res_prod = PROD_W'(res_idx) * PROD_W'(aligned_q);
  assign res_ofs  = res_alloc ? OFS_W'(res_prod + PROD_W'(HEADER_BYTES)) : '0;

  assign pend_valid_d = pend_load || (pend_valid_q && !pend_move);
  assign out_valid_d  = pend_move || (out_valid_q && !rsp_o.ready);

  // State machine and allocator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      aligned_q    <= ALN_W'(RST_ALIGNED);
      total_q      <= CNT_W'(RST_COUNT);
      free_q       <= CNT_W'(RST_COUNT);
      mark_q       <= '0;
      top_q        <= '0;
      nonempty_q   <= 1'b0;
      pop_idx_q    <= '0;
      zero_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      aligned_q    <= aligned_d;
      total_q      <= total_d;
      free_q       <= free_d;
      mark_q       <= mark_d;
      top_q        <= top_d;
      nonempty_q   <= nonempty_d;
      pop_idx_q    <= pop_idx_d;
      zero_q       <= zero_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Link memory: a push writes the old head, the head link is read every cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[req_i.free_index] <= {nonempty_q, top_q};
    end
    link_rd_q <= link_mem[top_q];
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_ok_q   <= res_ok;
      pend_idx_q  <= res_idx;
      pend_ofs_q  <= res_ofs;
      pend_free_q <= free_d;
    end
    if (pend_move) begin
      out_ok_q   <= pend_ok_q;
      out_idx_q  <= pend_idx_q;
      out_ofs_q  <= pend_ofs_q;
      out_free_q <= pend_free_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.ok           = out_ok_q;
  assign rsp_o.given_index  = out_idx_q;
  assign rsp_o.given_offset = out_ofs_q;
  assign rsp_o.free_count   = out_free_q;

  // The untouched region never reaches past the block count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mark_q <= total_q)
    else $error("untouched mark above block count");

  // A new result only enters the skid register when it is empty or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_load && pend_valid_q |-> pend_move)
    else $error("pending result overwritten");

  // A failed or non-allocating result carries no block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ok |-> rsp_o.given_index == '0 && rsp_o.given_offset == '0)
    else $error("failed result carries a block");

endmodule

@@ dv/fixed_block_free_list_allocator_tb.sv @@
module fixed_block_free_list_allocator_tb;
  import fbfla_pkg::*;

  // Unused operation code, sent to check that it changes nothing.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] ADDR_POOL  = {REG_POOL, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_BLOCK = {REG_BLOCK, 2'b00};

  localparam int unsigned POOL_MAX  = (1 << POOL_W) - 1;
  localparam int unsigned BLOCK_MAX = (1 << BLK_W) - 1;

  // Two copies of the pool state: one steers the stimulus ahead of time,
  // the other follows the requests in the order the block accepts them.
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  localparam int unsigned GEOMETRY_ITEMS = 8;
  localparam int unsigned SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
  } request_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] index;
    logic [OFS_W-1:0] offset;
    logic [CNT_W-1:0] count;
  } grant_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fbfla_req_if req_bus ();
  fbfla_rsp_if rsp_bus ();

  fixed_block_free_list_allocator i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pool state, one entry per copy.
  int unsigned      pool_cfg   [2];
  int unsigned      block_cfg  [2];
  logic [IDX_W:0]   link_mem   [2][MAX_BLOCKS];
  logic [IDX_W-1:0] top_idx    [2];
  logic             top_valid  [2];
  int unsigned      fresh_mark [2];
  int unsigned      block_cnt  [2];
  int unsigned      aligned_sz [2];
  int unsigned      free_cnt   [2];

  request_t    pending[$];
  grant_t      grants[$];
  int          held[$];
  int unsigned mismatches;
  int unsigned send_gap_pct;
  int unsigned take_stall_pct;
  logic        req_taken;

  // Derive the block geometry from the registers and empty the stack.
  function automatic void pool_setup(int c);
    int unsigned blocks;
    blocks = 0;
    aligned_sz[c] = (block_cfg[c] + POINTER_BYTES - 1) / POINTER_BYTES * POINTER_BYTES;
    if (aligned_sz[c] != 0 && pool_cfg[c] > HEADER_BYTES) begin
      blocks = (pool_cfg[c] - HEADER_BYTES) / aligned_sz[c];
      if (blocks > MAX_BLOCKS) begin
        blocks = MAX_BLOCKS;
      end
    end
    block_cnt[c]  = blocks;
    free_cnt[c]   = blocks;
    fresh_mark[c] = 0;
    top_idx[c]    = '0;
    top_valid[c]  = 1'b0;
  endfunction

  // Apply one request to a copy of the pool and return the grant it yields.
  function automatic grant_t pool_step(int c, request_t rq);
    grant_t g;
    g = '0;
    case (rq.func)
      FUNC_ALLOC: begin
        // Freed blocks go out first, then the untouched region.
        if (top_valid[c]) begin
          g.ok    = 1'b1;
          g.index = top_idx[c];
          if (link_mem[c][g.index][IDX_W]) begin
            top_idx[c] = link_mem[c][g.index][IDX_W-1:0];
          end else begin
            top_valid[c] = 1'b0;
          end
        end else if (fresh_mark[c] < block_cnt[c]) begin
          g.ok    = 1'b1;
          g.index = IDX_W'(fresh_mark[c]);
          fresh_mark[c]++;
        end
        if (g.ok) begin
          g.offset = OFS_W'(HEADER_BYTES + g.index * aligned_sz[c]);
          if (free_cnt[c] > 0) begin
            free_cnt[c]--;
          end
        end
      end
      FUNC_FREE: begin
        // Out-of-range indexes are dropped; double frees are pushed again.
        if (rq.index < block_cnt[c]) begin
          link_mem[c][rq.index] = top_valid[c] ? {1'b1, top_idx[c]} : '0;
          top_idx[c]   = rq.index;
          top_valid[c] = 1'b1;
          if (free_cnt[c] < FREE_SAT) begin
            free_cnt[c]++;
          end
          g.ok = 1'b1;
        end
      end
      FUNC_INIT: begin
        pool_setup(c);
        g.ok = (block_cnt[c] != 0);
      end
      default: begin
      end
    endcase
    g.count = CNT_W'(free_cnt[c]);
    return g;
  endfunction

  // Queue a request and track which blocks the stimulus currently holds.
  function automatic void plan(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx);
    request_t rq;
    grant_t   g;
    int       hit[$];
    rq.func  = fn;
    rq.index = idx;
    g = pool_step(PLAN, rq);
    if (fn == FUNC_INIT) begin
      held.delete();
    end else if (fn == FUNC_ALLOC && g.ok) begin
      held.push_back(g.index);
    end else if (fn == FUNC_FREE && g.ok) begin
      hit = held.find_first_index(x) with (x == idx);
      if (hit.size() != 0) begin
        held.delete(hit[0]);
      end
    end
    pending.push_back(rq);
  endfunction

  // Mostly allocations and frees of held blocks, with some noise mixed in.
  function automatic void plan_random();
    int unsigned pick;
    int          slot;
    pick = $urandom_range(99);
    if (pick < 45 || (pick < 85 && held.size() == 0)) begin
      plan(FUNC_ALLOC, IDX_W'($urandom));
    end else if (pick < 85) begin
      slot = $urandom_range(held.size() - 1);
      plan(FUNC_FREE, IDX_W'(held[slot]));
    end else if (pick < 93) begin
      plan(FUNC_FREE, IDX_W'($urandom));
    end else if (pick < 97) begin
      plan(FUNC_INIT, IDX_W'($urandom));
    end else begin
      plan(FUNC_SPARE, IDX_W'($urandom));
    end
  endfunction

  // Wait until every queued request has been sent and answered.
  task automatic drain();
    while (pending.size() != 0 || grants.size() != 0 || req_bus.valid) begin
      @(posedge clk);
    end
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogram the pool while the block is idle, then initialize it.
  task automatic set_geometry(int unsigned pool, int unsigned block);
    drain();
    apb_write(ADDR_POOL, DATA_W'(pool));
    apb_write(ADDR_BLOCK, DATA_W'(block));
    for (int c = 0; c < 2; c++) begin
      pool_cfg[c]  = pool;
      block_cfg[c] = block;
    end
    plan(FUNC_INIT, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request driver and response stall, both at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (!req_bus.valid || req_taken) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_bus.valid      <= 1'b1;
          req_bus.func       <= pending[0].func;
          req_bus.free_index <= pending[0].index;
          pending.delete(0);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Predict on each accepted request and check each accepted response.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      grants.push_back(pool_step(LIVE, request_t'({req_bus.func, req_bus.free_index})));
    end
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected grant: ok %0d index %0d offset %0d free %0d",
                   rsp_bus.ok, rsp_bus.given_index, rsp_bus.given_offset,
                   rsp_bus.free_count);
        end
      end else begin
        want = grants.pop_front();
        if (rsp_bus.ok !== want.ok || rsp_bus.given_index !== want.index ||
            rsp_bus.given_offset !== want.offset || rsp_bus.free_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("grant mismatch: ok %0d/%0d index %0d/%0d offset %0d/%0d free %0d/%0d",
                     want.ok, rsp_bus.ok, want.index, rsp_bus.given_index,
                     want.offset, rsp_bus.given_offset, want.count, rsp_bus.free_count);
          end
        end
      end
    end
    req_taken <= rst_n && req_bus.valid && req_bus.ready;
  end

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_bus.valid      = 1'b0;
    req_bus.func       = FUNC_ALLOC;
    req_bus.free_index = '0;
    rsp_bus.ready      = 1'b0;
    req_taken          = 1'b0;
    mismatches         = 0;
    send_gap_pct       = 13;
    take_stall_pct     = 71;
    for (int c = 0; c < 2; c++) begin
      pool_cfg[c]  = RST_POOL;
      block_cfg[c] = RST_BLOCK;
      pool_setup(c);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: untouched blocks, stack pops, double free, spare code.
    plan(FUNC_ALLOC, '0);
    plan(FUNC_ALLOC, '1);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, '1);
    plan(FUNC_FREE, '0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, IDX_W'(1));
    plan(FUNC_FREE, IDX_W'(1));
    plan(FUNC_ALLOC, '0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_SPARE, IDX_W'(10'h2AA));
    plan(FUNC_FREE, IDX_W'(10'h2AA));
    plan(FUNC_FREE, IDX_W'(10'h155));
    plan(FUNC_INIT, '0);
    plan(FUNC_ALLOC, '0);

    // Drive the free count into saturation with frees over a full pool.
    plan(FUNC_INIT, '0);
    repeat (MAX_BLOCKS + 8) plan(FUNC_FREE, IDX_W'($urandom));
    repeat (40) plan(FUNC_ALLOC, IDX_W'($urandom));

    // Zero block size, then a pool no larger than its header.
    set_geometry(RST_POOL, 0);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, '0);
    set_geometry(HEADER_BYTES, RST_BLOCK);
    plan(FUNC_ALLOC, '0);

    // Three blocks: run the pool dry and refill it.
    set_geometry(HEADER_BYTES + 3 * POINTER_BYTES, 5);
    repeat (4) plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, IDX_W'(3));
    plan(FUNC_FREE, IDX_W'(2));
    plan(FUNC_ALLOC, '0);

    // Largest registers: oversized blocks whose offsets wrap past 22 bits.
    set_geometry(POOL_MAX, BLOCK_MAX);
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, IDX_W'(MAX_BLOCKS - 2));
    plan(FUNC_ALLOC, '0);
    plan(FUNC_FREE, '1);
    plan(FUNC_ALLOC, '0);

    // Random requests over a range of geometries, under three stall patterns.
    for (int r = 0; r < 3; r++) begin
      drain();
      send_gap_pct   = (r == 0) ? 13 : (r == 1) ? 71 : 0;
      take_stall_pct = (r == 0) ? 71 : (r == 1) ? 13 : 0;
      for (int s = 0; s < 7; s++) begin
        case (s)
          0: set_geometry(RST_POOL, RST_BLOCK);
          1: set_geometry(88, 13);
          2: set_geometry(POOL_MAX, BLOCK_MAX);
          3: set_geometry(HEADER_BYTES, 1);
          4: set_geometry($urandom_range(4194312, 9), $urandom_range(4096, 1));
          5: set_geometry($urandom_range(300), 0);
          default: set_geometry($urandom_range(600, 9), $urandom_range(64, 1));
        endcase
        repeat (GEOMETRY_ITEMS) plan_random();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
